// ----- src/frame_power_complexity_features_top_defines.svh -----
// Assertion macros shared by the frame feature block.
`ifndef FRAME_POWER_COMPLEXITY_FEATURES_TOP_DEFINES_SVH
`define FRAME_POWER_COMPLEXITY_FEATURES_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is held.
`define FPCF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds across reset.
`define FPCF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FPCF_ASSERT(label, prop, msg)
`define FPCF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- src/fpcf_pkg.sv -----
`timescale 1ns / 1ps

package fpcf_pkg;

    // Field and register widths.
    localparam int SAMPLE_W   = 10;
    localparam int OFFSET_W   = 10;
    localparam int SCALE_W    = 4;
    localparam int GAIN_W     = 8;
    localparam int SCALED_W   = SAMPLE_W + SCALE_W;
    localparam int CORR_W     = 15;
    localparam int DELTA_W    = CORR_W + 1;
    localparam int MAG_W      = CORR_W;
    localparam int POWER_W    = 20;
    localparam int DIFF_W     = 20;
    localparam int CPLX_W     = 24;
    localparam int PEAK_W     = 14;
    localparam int IDX_W      = 5;
    localparam int NUM_W      = DIFF_W + GAIN_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;

    // Reset values of the registers.
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 10'd0;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 4'd1;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 8'd10;

    // Saturation limits.
    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};
    localparam logic [DIFF_W-1:0]  DIFF_MAX  = {DIFF_W{1'b1}};
    localparam logic [CPLX_W-1:0]  CPLX_MAX  = {CPLX_W{1'b1}};
    localparam logic [PEAK_W-1:0]  PEAK_MAX  = {PEAK_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic snap;
        logic mul_load;
        logic div_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_last;
    } t_sts;

endpackage

// ----- src/fpcf_in_if.sv -----
`timescale 1ns / 1ps

interface fpcf_in_if import fpcf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

// ----- src/fpcf_out_if.sv -----
`timescale 1ns / 1ps

interface fpcf_out_if import fpcf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [POWER_W-1:0] frame_power;
    logic [CPLX_W-1:0]  frame_complexity;
    logic [PEAK_W-1:0]  peak_magnitude;
    logic [IDX_W-1:0]   peak_index;
    logic               zero_power;

    modport source (output valid, output frame_power, output frame_complexity,
                    output peak_magnitude, output peak_index, output zero_power,
                    input ready);
    modport sink   (input valid, input frame_power, input frame_complexity,
                    input peak_magnitude, input peak_index, input zero_power,
                    output ready);
endinterface

// ----- src/fpcf_accum.sv -----
`timescale 1ns / 1ps

module fpcf_accum import fpcf_pkg::*; #(
    parameter int FRAME_LENGTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic [SCALE_W-1:0]  i_scale,
    output t_sts                o_sts,
    output logic [POWER_W-1:0]  o_power,
    output logic [DIFF_W-1:0]   o_diff,
    output logic [PEAK_W-1:0]   o_peak,
    output logic [IDX_W-1:0]    o_index
);

    localparam int CNT_W = $clog2(FRAME_LENGTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LENGTH - 1);

    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [POWER_W-1:0]       r_pow, n_pow;
    logic [DIFF_W-1:0]        r_diff, n_diff;
    logic signed [CORR_W-1:0] r_prev;
    logic [PEAK_W-1:0]        r_peak, n_peak;
    logic [IDX_W-1:0]         r_idx, n_idx;

    logic [POWER_W-1:0]       r_snap_pow;
    logic [DIFF_W-1:0]        r_snap_diff;
    logic [PEAK_W-1:0]        r_snap_peak;
    logic [IDX_W-1:0]         r_snap_idx;

    logic [SCALED_W-1:0]       w_scaled;
    logic signed [CORR_W-1:0]  w_corr;
    logic [MAG_W-1:0]          w_mag;
    logic [PEAK_W-1:0]         w_mag_pk;
    logic signed [DELTA_W-1:0] w_delta;
    logic [DELTA_W-1:0]        w_delta_abs;
    logic [POWER_W:0]          w_pow_sum;
    logic [DIFF_W:0]           w_diff_sum;
    logic [CNT_W+IDX_W-1:0]    w_cnt_ext;
    logic                      w_last;

    // Scale the sample, remove the background level and take magnitudes.
    assign w_scaled    = SCALED_W'(i_sample) * SCALED_W'(i_scale);
    assign w_corr      = $signed({1'b0, w_scaled}) - $signed(CORR_W'(i_offset));
    assign w_mag       = w_corr[CORR_W-1] ? MAG_W'(-w_corr) : MAG_W'(w_corr);
    assign w_mag_pk    = (|w_mag[MAG_W-1:PEAK_W]) ? PEAK_MAX : w_mag[PEAK_W-1:0];
    assign w_delta     = DELTA_W'(w_corr) - DELTA_W'(r_prev);
    assign w_delta_abs = w_delta[DELTA_W-1] ? DELTA_W'(-w_delta) : DELTA_W'(w_delta);
    assign w_pow_sum   = (POWER_W + 1)'(r_pow) + (POWER_W + 1)'(w_mag);
    assign w_diff_sum  = (DIFF_W + 1)'(r_diff) + (DIFF_W + 1)'(w_delta_abs);
    assign w_cnt_ext   = (CNT_W + IDX_W)'(r_cnt);
    assign w_last      = (r_cnt == CNT_LAST);

    // Running frame values after the current sample.
    always_comb begin
        n_pow  = w_pow_sum[POWER_W] ? POWER_MAX : w_pow_sum[POWER_W-1:0];
        n_diff = r_diff;
        if (r_cnt != '0) begin
            n_diff = w_diff_sum[DIFF_W] ? DIFF_MAX : w_diff_sum[DIFF_W-1:0];
        end
        n_peak = r_peak;
        n_idx  = r_idx;
        if (w_mag_pk > r_peak) begin
            n_peak = w_mag_pk;
            n_idx  = w_cnt_ext[IDX_W-1:0];
        end
        n_cnt = w_last ? '0 : r_cnt + 1'b1;
    end

    // Frame accumulators; the last sample clears them for the next frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pow  <= '0;
            r_diff <= '0;
            r_prev <= '0;
            r_peak <= '0;
            r_idx  <= '0;
        end else if (i_cmd.accept) begin
            r_cnt  <= n_cnt;
            r_prev <= w_corr;
            if (w_last) begin
                r_pow  <= '0;
                r_diff <= '0;
                r_peak <= '0;
                r_idx  <= '0;
            end else begin
                r_pow  <= n_pow;
                r_diff <= n_diff;
                r_peak <= n_peak;
                r_idx  <= n_idx;
            end
        end
    end

    // Finished frame held for the divider and the result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_snap_pow  <= n_pow;
            r_snap_diff <= n_diff;
            r_snap_peak <= n_peak;
            r_snap_idx  <= n_idx;
        end
    end

    assign o_sts.is_last = w_last;
    assign o_power       = r_snap_pow;
    assign o_diff        = r_snap_diff;
    assign o_peak        = r_snap_peak;
    assign o_index       = r_snap_idx;

endmodule

// ----- src/fpcf_div.sv -----
`timescale 1ns / 1ps

module fpcf_div import fpcf_pkg::*; (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic [DIFF_W-1:0]  i_diff,
    input  logic [GAIN_W-1:0]  i_gain,
    input  logic [POWER_W-1:0] i_power,
    output logic [NUM_W-1:0]   o_quotient
);

    logic [NUM_W-1:0]   r_work;
    logic [POWER_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0]   w_product;
    logic [POWER_W:0]   w_shift;
    logic [POWER_W:0]   w_sub;
    logic               w_ge;

    // Numerator: difference sum times gain.
    assign w_product = NUM_W'(i_diff) * NUM_W'(i_gain);

    // One restoring step: bring down the next numerator bit and try the divisor.
    assign w_shift = {r_rem, r_work[NUM_W-1]};
    assign w_ge    = (w_shift >= (POWER_W + 1)'(i_power));
    assign w_sub   = w_shift - (POWER_W + 1)'(i_power);
    assign n_rem   = w_ge ? w_sub[POWER_W-1:0] : w_shift[POWER_W-1:0];

    // Numerator bits shift out at the top while quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_work <= w_product;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_work <= {r_work[NUM_W-2:0], w_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_quotient = r_work;

endmodule

// ----- src/fpcf_ctrl.sv -----
`timescale 1ns / 1ps
`include "frame_power_complexity_features_top_defines.svh"

module fpcf_ctrl import fpcf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_accept;

    // The last sample of a frame waits until the previous result has gone.
    assign o_in_ready = !(i_sts.is_last && (r_state != ST_IDLE));
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_cmd.accept   = w_accept;
    assign o_cmd.snap     = w_accept && i_sts.is_last;
    assign o_cmd.mul_load = (r_state == ST_MUL);
    assign o_cmd.div_step = (r_state == ST_DIV);
    assign o_out_valid    = (r_state == ST_OUT);

    // Result sequencer: multiply, one quotient bit per cycle, then present.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.snap) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
                n_step  = '0;
            end
            ST_DIV: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // A frame is only handed over while the divider and result are free.
    `FPCF_ASSERT(a_snap_when_idle, o_cmd.snap |-> (r_state == ST_IDLE), "snap while busy")
    `FPCF_ASSERT(a_snap_starts, o_cmd.snap |=> (r_state == ST_MUL), "snap did not start")
    `FPCF_ASSERT(a_div_ends, (o_cmd.div_step && (r_step == STEP_LAST)) |=> o_out_valid,
        "division did not end in a result")
    `FPCF_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == ST_IDLE && !o_out_valid),
        "reset did not clear the sequencer")

endmodule

// ----- src/frame_power_complexity_features_top.sv -----
`timescale 1ns / 1ps
// Throughput: one sample per cycle; the last sample of a frame is held off until the
// previous frame's result has been taken, so with the result taken at once, frames of
// 31 or more samples run at full rate.
// The result is valid once the gain multiply and then the bit-serial divider have run after the
// last sample of its frame is accepted, and it is held until taken.
// Reset: synchronous, active low; registers return to offset 0, scale 1, gain 10 and the
// frame accumulators, sample counter and result sequencer are cleared.

module frame_power_complexity_features_top import fpcf_pkg::*; #(
    parameter int FRAME_LENGTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fpcf_in_if.sink               i_in,
    fpcf_out_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [OFFSET_W-1:0] r_offset;
    logic [SCALE_W-1:0]  r_scale;
    logic [GAIN_W-1:0]   r_gain;

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [POWER_W-1:0] w_power;
    logic [DIFF_W-1:0]  w_diff;
    logic [PEAK_W-1:0]  w_peak;
    logic [IDX_W-1:0]   w_index;
    logic [NUM_W-1:0]   w_quotient;
    logic               w_zero;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RST;
            r_scale  <= SCALE_RST;
            r_gain   <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                REG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                REG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fpcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (w_cmd)
    );

    fpcf_accum #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_sample (i_in.adc_sample),
        .i_offset (r_offset),
        .i_scale  (r_scale),
        .o_sts    (w_sts),
        .o_power  (w_power),
        .o_diff   (w_diff),
        .o_peak   (w_peak),
        .o_index  (w_index)
    );

    fpcf_div u_div (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_diff     (w_diff),
        .i_gain     (r_gain),
        .i_power    (w_power),
        .o_quotient (w_quotient)
    );

    // Result fields; zero power forces complexity to zero, large ratios saturate.
    assign w_zero                 = (w_power == '0);
    assign o_res.frame_power      = w_power;
    assign o_res.peak_magnitude   = w_peak;
    assign o_res.peak_index       = w_index;
    assign o_res.zero_power       = w_zero;
    assign o_res.frame_complexity = w_zero ? '0 :
                                    (|w_quotient[NUM_W-1:CPLX_W]) ? CPLX_MAX :
                                    w_quotient[CPLX_W-1:0];

endmodule

// ----- tb/frame_power_complexity_features_top_test.sv -----
`timescale 1ns / 1ps

module frame_power_complexity_features_top_test import fpcf_pkg::*; ();

    localparam int FRAME_LEN    = 32;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 155;

    // Index that decodes to no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [POWER_W-1:0] frame_power;
        logic [CPLX_W-1:0]  frame_complexity;
        logic [PEAK_W-1:0]  peak_magnitude;
        logic [IDX_W-1:0]   peak_index;
        logic               zero_power;
    } t_frame_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fpcf_in_if  sample_if ();
    fpcf_out_if result_if ();

    frame_power_complexity_features_top #(
        .FRAME_LENGTH(FRAME_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (sample_if),
        .o_res      (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Register copies and frame accumulators of the feature predictor.
    logic [OFFSET_W-1:0] offset_reg = OFFSET_RST;
    logic [SCALE_W-1:0]  scale_reg  = SCALE_RST;
    logic [GAIN_W-1:0]   gain_reg   = GAIN_RST;

    int              frame_pos = 0;
    int              power_acc = 0;
    int              diff_acc  = 0;
    int              prev_corr = 0;
    int              peak_acc  = 0;
    logic [IDX_W-1:0] peak_pos = '0;

    logic [SAMPLE_W-1:0] sample_queue[$];
    t_frame_result       pending_frames[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  sample_taken   = 1'b0;
    int  last_sample    = 0;

    // Folds one sample into the running frame and reports the frame features on its
    // last sample.
    function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] raw,
                                             output t_frame_result res);
        int     corr;
        int     mag;
        int     peak_mag;
        int     delta;
        longint quotient;
        res = '0;
        corr = int'(raw) * int'(scale_reg) - int'(offset_reg);
        mag = (corr < 0) ? -corr : corr;
        peak_mag = (mag > int'(PEAK_MAX)) ? int'(PEAK_MAX) : mag;
        power_acc = (power_acc + mag > int'(POWER_MAX)) ? int'(POWER_MAX) : power_acc + mag;
        // The first sample of a frame has no predecessor in the same frame.
        if (frame_pos != 0) begin
            delta = (corr - prev_corr < 0) ? prev_corr - corr : corr - prev_corr;
            diff_acc = (diff_acc + delta > int'(DIFF_MAX)) ? int'(DIFF_MAX) : diff_acc + delta;
        end
        // Strictly greater keeps the first sample of a tie.
        if (peak_mag > peak_acc) begin
            peak_acc = peak_mag;
            peak_pos = frame_pos[IDX_W-1:0];
        end
        prev_corr = corr;
        frame_pos++;
        if (frame_pos < FRAME_LEN) begin
            return 1'b0;
        end
        res.frame_power    = power_acc[POWER_W-1:0];
        res.peak_magnitude = peak_acc[PEAK_W-1:0];
        res.peak_index     = peak_pos;
        if (power_acc == 0) begin
            res.zero_power = 1'b1;
        end else begin
            quotient = longint'(diff_acc) * longint'(gain_reg) / longint'(power_acc);
            if (quotient > longint'(CPLX_MAX)) begin
                quotient = longint'(CPLX_MAX);
            end
            res.frame_complexity = quotient[CPLX_W-1:0];
        end
        frame_pos = 0;
        power_acc = 0;
        diff_acc  = 0;
        peak_acc  = 0;
        peak_pos  = '0;
        return 1'b1;
    endfunction

    // Random sample mix: full range, values that nearly cancel the offset, the extremes,
    // and repeats of the last value to make peak ties.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int choice;
        int raw;
        choice = $urandom_range(9);
        if (choice <= 3) begin
            raw = $urandom_range(1023);
        end else if (choice <= 5) begin
            if (scale_reg == 0) begin
                raw = $urandom_range(1023);
            end else begin
                raw = int'(offset_reg) / int'(scale_reg) + $urandom_range(6) - 3;
            end
        end else if (choice == 6) begin
            raw = 0;
        end else if (choice == 7) begin
            raw = 1023;
        end else begin
            raw = last_sample;
        end
        if (raw < 0) begin
            raw = 0;
        end else if (raw > 1023) begin
            raw = 1023;
        end
        last_sample = raw;
        return raw[SAMPLE_W-1:0];
    endfunction

    // One register write; the predictor copy follows the same decode and masking.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        unique case (idx)
            REG_OFFSET: offset_reg = data[OFFSET_W-1:0];
            REG_SCALE:  scale_reg  = data[SCALE_W-1:0];
            REG_GAIN:   gain_reg   = data[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Writes all three registers; unused upper data bits carry random values.
    task automatic configure(input int offset_val, input int scale_val, input int gain_val);
        logic [CFG_DATA_W-1:0] data;
        data = offset_val[CFG_DATA_W-1:0];
        write_register(REG_OFFSET, data);
        data = CFG_DATA_W'($urandom);
        data[SCALE_W-1:0] = scale_val[SCALE_W-1:0];
        write_register(REG_SCALE, data);
        data = CFG_DATA_W'($urandom);
        data[GAIN_W-1:0] = gain_val[GAIN_W-1:0];
        write_register(REG_GAIN, data);
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        unique case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 86;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 86;
            end
            default: begin
                send_idle_pct  = 15;
                recv_stall_pct = 15;
            end
        endcase
    endtask

    // Holds the sender until every queued request is sent and every frame result has
    // arrived, then lets the block's pipeline settle.
    task automatic wait_drained();
        while (sample_queue.size() != 0 || sample_if.valid || pending_frames.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Sample driver and result ready, both updated on the falling edge.
    always @(negedge i_clk) begin
        if (!sample_if.valid || sample_taken) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                sample_if.adc_sample <= sample_queue.pop_front();
                sample_if.valid      <= 1'b1;
            end else begin
                sample_if.valid <= 1'b0;
            end
        end
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predicts on each accepted sample request and checks each accepted result.
    always @(posedge i_clk) begin
        t_frame_result want;
        t_frame_result got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            sample_taken = i_rst_n && sample_if.valid && sample_if.ready;
            if (sample_taken) begin
                if (accumulate_sample(sample_if.adc_sample, want)) begin
                    pending_frames.push_back(want);
                end
            end
            if (i_rst_n && result_if.valid && result_if.ready) begin
                got.frame_power      = result_if.frame_power;
                got.frame_complexity = result_if.frame_complexity;
                got.peak_magnitude   = result_if.peak_magnitude;
                got.peak_index       = result_if.peak_index;
                got.zero_power       = result_if.zero_power;
                if (pending_frames.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: frame result expected none actual power %0d", $time,
                             got.frame_power);
                end else begin
                    want = pending_frames.pop_front();
                    if (got.frame_power != want.frame_power) begin
                        mismatch_count++;
                        $display("%0t: frame_power expected %0d actual %0d", $time,
                                 want.frame_power, got.frame_power);
                    end
                    if (got.frame_complexity != want.frame_complexity) begin
                        mismatch_count++;
                        $display("%0t: frame_complexity expected %0d actual %0d", $time,
                                 want.frame_complexity, got.frame_complexity);
                    end
                    if (got.peak_magnitude != want.peak_magnitude) begin
                        mismatch_count++;
                        $display("%0t: peak_magnitude expected %0d actual %0d", $time,
                                 want.peak_magnitude, got.peak_magnitude);
                    end
                    if (got.peak_index != want.peak_index) begin
                        mismatch_count++;
                        $display("%0t: peak_index expected %0d actual %0d", $time,
                                 want.peak_index, got.peak_index);
                    end
                    if (got.zero_power != want.zero_power) begin
                        mismatch_count++;
                        $display("%0t: zero_power expected %0d actual %0d", $time,
                                 want.zero_power, got.zero_power);
                    end
                end
            end
        end
    end

    // Stimulus sequence: directed samples, then random phases with varied settings.
    initial begin
        int         phase_offset[PHASE_COUNT];
        int         phase_scale[PHASE_COUNT];
        int         phase_gain[PHASE_COUNT];
        t_idle_mode phase_mode[PHASE_COUNT];
        logic [SAMPLE_W-1:0] directed_pos[12];
        logic [SAMPLE_W-1:0] directed_neg[12];
        int off_val;
        int scale_val;
        int gain_val;

        // A negative entry picks a random setting for that phase.
        phase_offset = '{0, 1023, 0, 512, 1023, -1, -1, -1};
        phase_scale  = '{15, 15, 0, 1, 1, -1, -1, -1};
        phase_gain   = '{255, 0, 128, 255, 1, -1, -1, -1};
        phase_mode   = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                         IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        directed_pos = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1, 10'd1022,
                         10'd512, 10'd511, 10'd1023, 10'd0, 10'd682, 10'd341};
        directed_neg = '{10'd0, 10'd1023, 10'd0, 10'd1022, 10'd1, 10'd0,
                         10'd512, 10'd1023, 10'd1023, 10'd2, 10'd0, 10'd767};

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = REG_OFFSET;
        i_cfg_data           = '0;
        sample_if.valid      = 1'b0;
        sample_if.adc_sample = '0;
        result_if.ready      = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at reset settings: the extremes and peak ties.
        set_idle_mode(IDLE_NONE);
        foreach (directed_pos[k]) begin
            sample_queue.push_back(directed_pos[k]);
        end
        wait_drained();

        // Largest offset makes corrected values negative, mid-frame.
        write_register(REG_OFFSET, 10'd1023);
        foreach (directed_neg[k]) begin
            sample_queue.push_back(directed_neg[k]);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained();
            off_val   = (phase_offset[p] < 0) ? $urandom_range(1023) : phase_offset[p];
            scale_val = (phase_scale[p] < 0) ? $urandom_range(15) : phase_scale[p];
            gain_val  = (phase_gain[p] < 0) ? $urandom_range(255) : phase_gain[p];
            if (p == 3) begin
                write_register(REG_UNUSED, CFG_DATA_W'($urandom));
            end
            configure(off_val, scale_val, gain_val);
            set_idle_mode(phase_mode[p]);
            repeat (PHASE_ITEMS) sample_queue.push_back(pick_sample());
        end

        wait_drained();
        if (mismatch_count == 0 && pending_frames.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
